// File: hdl/timezone_record_parser_top_assert.svh
// assertion macros for the time-zone record parser
`ifndef TIMEZONE_RECORD_PARSER_TOP_ASSERT_SVH
`define TIMEZONE_RECORD_PARSER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TZRP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TZRP_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define TZRP_ASSERT(label, clk, rst_n, prop, msg)
`define TZRP_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// File: hdl/tzrp_pkg.sv
// ----------------------------------------------------------------------------
// tzrp_pkg
// types, phase codes and template tables of the time-zone record parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tzrp_pkg;

	localparam int NameLimitDefault = 64;

	typedef enum logic [5:0] {
		PH_HDR_TAG = 6'd0, PH_HDR_IDS = 6'd1, PH_MAJOR = 6'd2, PH_MINOR = 6'd3,
		PH_CLS_TAG = 6'd4, PH_CLS_ID = 6'd5, PH_TZ_LEN = 6'd6, PH_TZ_TXT = 6'd7,
		PH_COUNT = 6'd8, PH_M0_LEN = 6'd9, PH_M0_TXT = 6'd10, PH_M1_LEN = 6'd11,
		PH_M1_TXT = 6'd12, PH_M2_LEN = 6'd13, PH_M2_TXT = 6'd14, PH_M3_LEN = 6'd15,
		PH_M3_TXT = 6'd16, PH_TYPES = 6'd17, PH_HT_LEN = 6'd18, PH_HT_TXT = 6'd19,
		PH_PRIM = 6'd20, PH_CACHE_TAG = 6'd21, PH_CACHE_REF = 6'd22, PH_OFFSET = 6'd23,
		PH_STD_TAG = 6'd24, PH_STD_ID = 6'd25, PH_STD_LEN = 6'd26, PH_STD_BODY = 6'd27,
		PH_DAY_TAG = 6'd28, PH_DAY_ID = 6'd29, PH_DAY_LEN = 6'd30, PH_DAY_BODY = 6'd31,
		PH_DONE = 6'd32
	} phase_t;

	typedef enum logic [1:0] {
		KIND_STD = 2'd0,
		KIND_DAY = 2'd1,
		KIND_VERDICT = 2'd2
	} kind_t;

	// classified work handed from front to back
	typedef struct packed {
		logic          name_vld;
		logic          name_side;
		logic [7:0]    name_char;
		logic          name_final;
		logic          verd_vld;
		logic          verd_bad;
		logic [1:0]    presence;
		logic [63:0]   offset;
	} work_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  name_char;
		logic        name_final;
		logic        status;
		logic        standard_present;
		logic        daylight_present;
		logic [63:0] tick_offset;
		logic        run_last;
	} result_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} item_t;

	// template texts, first character in the top byte
	localparam logic [8*28-1:0] TzClassText = "System.CurrentSystemTimeZone";
	localparam logic [8*23-1:0] CacheMemberText = {"m_Cached", "DaylightChanges"};
	localparam logic [8*13-1:0] OffsetMemberText = {"m_ticks", "Offset"};
	localparam logic [8*14-1:0] StdMemberText = {"m_standard", "Name"};
	localparam logic [8*14-1:0] DayMemberText = {"m_daylight", "Name"};
	localparam logic [8*28-1:0] TableClassText = "System.Collections.Hashtable";

	function automatic logic [4:0] tmpl_size(input logic [2:0] idx);
		case (idx)
			3'd0: tmpl_size = 5'd28;
			3'd1: tmpl_size = 5'd23;
			3'd2: tmpl_size = 5'd13;
			3'd3: tmpl_size = 5'd14;
			3'd4: tmpl_size = 5'd14;
			3'd5: tmpl_size = 5'd28;
			default: tmpl_size = 5'd0;
		endcase
	endfunction

	function automatic logic [7:0] tmpl_char(input logic [2:0] idx, input logic [4:0] pos);
		logic [8*28-1:0] text;
		logic [4:0]      txt_len;
		txt_len = tmpl_size(idx);
		case (idx)
			3'd0: text = TzClassText;
			3'd1: text = 224'(CacheMemberText);
			3'd2: text = 224'(OffsetMemberText);
			3'd3: text = 224'(StdMemberText);
			3'd4: text = 224'(DayMemberText);
			3'd5: text = TableClassText;
			default: text = '0;
		endcase
		if (pos < txt_len) tmpl_char = text[8 * (txt_len - 5'd1 - pos) +: 8];
		else tmpl_char = 8'd0;
	endfunction

endpackage

// File: hdl/tzrp_stream_if.sv
// ----------------------------------------------------------------------------
// tzrp_stream_if
// valid/ready channel with a generic payload
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface tzrp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: hdl/tzrp_front.sv
// ----------------------------------------------------------------------------
// tzrp_front
// accepts record bytes, walks the template and classifies each byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tzrp_front #(
	parameter int NAME_LIMIT = tzrp_pkg::NameLimitDefault
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_vld,
	input  wire tzrp_pkg::item_t in_item,
	output logic                in_rdy,
	output logic                wk_vld,
	output tzrp_pkg::work_t     wk,
	input  wire logic           wk_rdy
);
	tzrp_pkg::phase_t phase_q, ph_n;
	logic [7:0]  pos_q, pos_n;
	logic [34:0] len_q, len_n;
	logic [2:0]  vcnt_q, vcnt_n;
	logic [31:0] word_q, word_n;
	logic [63:0] off_q, off_n;
	logic [7:0]  left_q, left_n;
	logic [1:0]  pres_q, pres_n;
	logic        given_q, given_n;
	logic        bad, ok_v, adv;
	tzrp_pkg::phase_t adv_ph;
	logic [7:0]  b;
	logic        side;
	logic [34:0] len_acc;
	logic        v_done, v_over;
	logic [2:0]  tidx;
	logic [7:0]  pos_inc;
	logic        fire;

	assign in_rdy = wk_rdy;
	assign fire = in_vld && in_rdy;
	assign b = in_item.data_byte;
	assign side = (phase_q >= tzrp_pkg::PH_DAY_TAG) && (phase_q <= tzrp_pkg::PH_DAY_BODY);
	assign pos_inc = pos_q + 8'd1;
	assign len_acc = len_q | (35'(b[6:0]) << (7 * vcnt_q));
	assign v_done = !b[7];
	assign v_over = b[7] && (vcnt_q >= 3'd4);

	// template string selected by the current length or text phase
	always_comb begin
		case (phase_q)
			tzrp_pkg::PH_M0_LEN, tzrp_pkg::PH_M0_TXT: tidx = 3'd1;
			tzrp_pkg::PH_M1_LEN, tzrp_pkg::PH_M1_TXT: tidx = 3'd2;
			tzrp_pkg::PH_M2_LEN, tzrp_pkg::PH_M2_TXT: tidx = 3'd3;
			tzrp_pkg::PH_M3_LEN, tzrp_pkg::PH_M3_TXT: tidx = 3'd4;
			tzrp_pkg::PH_HT_LEN, tzrp_pkg::PH_HT_TXT: tidx = 3'd5;
			default: tidx = 3'd0;
		endcase
	end

	always_comb begin
		bad = 1'b0;
		ok_v = 1'b0;
		adv = 1'b0;
		adv_ph = phase_q;
		pos_n = pos_q;
		len_n = len_q;
		vcnt_n = vcnt_q;
		word_n = word_q;
		off_n = off_q;
		left_n = left_q;
		pres_n = pres_q;
		wk = '0;
		case (phase_q)
			tzrp_pkg::PH_HDR_TAG: begin
				if (b != 8'd0) bad = 1'b1;
				else begin adv = 1'b1; adv_ph = tzrp_pkg::PH_HDR_IDS; end
			end
			tzrp_pkg::PH_HDR_IDS: begin
				pos_n = pos_inc;
				if (pos_inc >= 8'd8) begin adv = 1'b1; adv_ph = tzrp_pkg::PH_MAJOR; end
			end
			tzrp_pkg::PH_MAJOR, tzrp_pkg::PH_COUNT: begin
				word_n = word_q | (32'(b) << (8 * pos_q[1:0]));
				pos_n = pos_inc;
				if (pos_inc >= 8'd4) begin
					if (word_n != ((phase_q == tzrp_pkg::PH_MAJOR) ? 32'd1 : 32'd4)) bad = 1'b1;
					else begin
						adv = 1'b1;
						adv_ph = (phase_q == tzrp_pkg::PH_MAJOR) ? tzrp_pkg::PH_MINOR
							: tzrp_pkg::PH_M0_LEN;
					end
				end
			end
			tzrp_pkg::PH_MINOR, tzrp_pkg::PH_CLS_ID, tzrp_pkg::PH_CACHE_REF: begin
				pos_n = pos_inc;
				if (pos_inc >= 8'd4) begin
					adv = 1'b1;
					adv_ph = (phase_q == tzrp_pkg::PH_MINOR) ? tzrp_pkg::PH_CLS_TAG
						: (phase_q == tzrp_pkg::PH_CLS_ID) ? tzrp_pkg::PH_TZ_LEN
						: tzrp_pkg::PH_OFFSET;
				end
			end
			tzrp_pkg::PH_CLS_TAG: begin
				if (b != 8'd4) bad = 1'b1;
				else begin adv = 1'b1; adv_ph = tzrp_pkg::PH_CLS_ID; end
			end
			tzrp_pkg::PH_TYPES: begin
				if (b != ((pos_q[1:0] == 2'd0) ? 8'd3 : (pos_q[1:0] == 2'd1) ? 8'd0 : 8'd1))
					bad = 1'b1;
				else begin
					pos_n = pos_inc;
					if (pos_inc >= 8'd4) begin adv = 1'b1; adv_ph = tzrp_pkg::PH_HT_LEN; end
				end
			end
			tzrp_pkg::PH_PRIM: begin
				if (b != 8'd9) bad = 1'b1;
				else begin adv = 1'b1; adv_ph = tzrp_pkg::PH_CACHE_TAG; end
			end
			tzrp_pkg::PH_CACHE_TAG: begin
				if (b == 8'd9) begin adv = 1'b1; adv_ph = tzrp_pkg::PH_CACHE_REF; end
				else if (b == 8'd10) begin adv = 1'b1; adv_ph = tzrp_pkg::PH_OFFSET; end
				else bad = 1'b1;
			end
			tzrp_pkg::PH_OFFSET: begin
				off_n = off_q | (64'(b) << (8 * pos_q[2:0]));
				pos_n = pos_inc;
				if (pos_inc >= 8'd8) begin adv = 1'b1; adv_ph = tzrp_pkg::PH_STD_TAG; end
			end
			tzrp_pkg::PH_STD_TAG, tzrp_pkg::PH_DAY_TAG: begin
				if (b == 8'd6) begin
					adv = 1'b1;
					adv_ph = side ? tzrp_pkg::PH_DAY_ID : tzrp_pkg::PH_STD_ID;
				end else if (b != 8'd10) bad = 1'b1;
				else if (side) ok_v = 1'b1;
				else begin adv = 1'b1; adv_ph = tzrp_pkg::PH_DAY_TAG; end
			end
			tzrp_pkg::PH_STD_ID, tzrp_pkg::PH_DAY_ID: begin
				pos_n = pos_inc;
				if (pos_inc >= 8'd4) begin
					adv = 1'b1;
					adv_ph = side ? tzrp_pkg::PH_DAY_LEN : tzrp_pkg::PH_STD_LEN;
				end
			end
			tzrp_pkg::PH_STD_LEN, tzrp_pkg::PH_DAY_LEN: begin
				len_n = len_acc;
				vcnt_n = vcnt_q + 3'd1;
				if (v_over || (v_done && len_acc >= 35'(NAME_LIMIT))) bad = 1'b1;
				else if (v_done) begin
					left_n = 8'(len_acc);
					if (len_acc == 35'd0) begin
						pres_n = pres_q | (side ? 2'b10 : 2'b01);
						if (side) ok_v = 1'b1;
						else begin adv = 1'b1; adv_ph = tzrp_pkg::PH_DAY_TAG; end
					end else begin
						adv = 1'b1;
						adv_ph = side ? tzrp_pkg::PH_DAY_BODY : tzrp_pkg::PH_STD_BODY;
					end
				end
			end
			tzrp_pkg::PH_STD_BODY, tzrp_pkg::PH_DAY_BODY: begin
				if (left_q != 8'd0) left_n = left_q - 8'd1;
				wk.name_vld = 1'b1;
				wk.name_side = side;
				wk.name_char = b;
				wk.name_final = (left_n == 8'd0);
				if (left_n == 8'd0) begin
					pres_n = pres_q | (side ? 2'b10 : 2'b01);
					if (side) ok_v = 1'b1;
					else begin adv = 1'b1; adv_ph = tzrp_pkg::PH_DAY_TAG; end
				end
			end
			tzrp_pkg::PH_DONE: ;
			tzrp_pkg::PH_TZ_LEN, tzrp_pkg::PH_M0_LEN, tzrp_pkg::PH_M1_LEN,
			tzrp_pkg::PH_M2_LEN, tzrp_pkg::PH_M3_LEN, tzrp_pkg::PH_HT_LEN: begin
				len_n = len_acc;
				vcnt_n = vcnt_q + 3'd1;
				if (v_over || (v_done && len_acc != 35'(tzrp_pkg::tmpl_size(tidx)))) bad = 1'b1;
				else if (v_done) begin
					adv = 1'b1;
					adv_ph = tzrp_pkg::phase_t'(phase_q + 6'd1);
				end
			end
			tzrp_pkg::PH_TZ_TXT, tzrp_pkg::PH_M0_TXT, tzrp_pkg::PH_M1_TXT,
			tzrp_pkg::PH_M2_TXT, tzrp_pkg::PH_M3_TXT, tzrp_pkg::PH_HT_TXT: begin
				if (pos_q >= 8'(tzrp_pkg::tmpl_size(tidx))
					|| b != tzrp_pkg::tmpl_char(tidx, pos_q[4:0])) bad = 1'b1;
				else begin
					pos_n = pos_inc;
					if (pos_inc >= 8'(tzrp_pkg::tmpl_size(tidx))) begin
						adv = 1'b1;
						case (phase_q)
							tzrp_pkg::PH_TZ_TXT: adv_ph = tzrp_pkg::PH_COUNT;
							tzrp_pkg::PH_M3_TXT: adv_ph = tzrp_pkg::PH_TYPES;
							tzrp_pkg::PH_HT_TXT: adv_ph = tzrp_pkg::PH_PRIM;
							default: adv_ph = tzrp_pkg::phase_t'(phase_q + 6'd1);
						endcase
					end
				end
			end
			default: bad = 1'b1;
		endcase
		ph_n = phase_q;
		if (adv || ok_v || bad) begin
			ph_n = adv ? adv_ph : tzrp_pkg::PH_DONE;
			pos_n = '0;
			word_n = '0;
			len_n = '0;
			vcnt_n = '0;
		end
		given_n = given_q || ok_v || bad;
		wk.verd_vld = ok_v || bad || (in_item.end_of_stream && !given_q);
		wk.verd_bad = !ok_v;
		wk.presence = pres_n;
		wk.offset = off_n;
	end

	assign wk_vld = fire && (wk.name_vld || wk.verd_vld);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tzrp_pkg::PH_HDR_TAG;
			pos_q <= '0;
			len_q <= '0;
			vcnt_q <= '0;
			word_q <= '0;
			off_q <= '0;
			left_q <= '0;
			pres_q <= '0;
			given_q <= 1'b0;
		end else if (fire) begin
			if (in_item.end_of_stream) begin
				phase_q <= tzrp_pkg::PH_HDR_TAG;
				pos_q <= '0;
				len_q <= '0;
				vcnt_q <= '0;
				word_q <= '0;
				off_q <= '0;
				left_q <= '0;
				pres_q <= '0;
				given_q <= 1'b0;
			end else begin
				phase_q <= ph_n;
				pos_q <= pos_n;
				len_q <= len_n;
				vcnt_q <= vcnt_n;
				word_q <= word_n;
				off_q <= off_n;
				left_q <= left_n;
				pres_q <= pres_n;
				given_q <= given_n;
			end
		end
	end
endmodule
`default_nettype wire

// File: hdl/tzrp_queue.sv
// ----------------------------------------------------------------------------
// tzrp_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tzrp_queue (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       wr_vld,
	input  wire tzrp_pkg::work_t wr_data,
	output logic            wr_rdy,
	output logic            rd_vld,
	output tzrp_pkg::work_t rd_data,
	input  wire logic       rd_rdy
);
	tzrp_pkg::work_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_rdy = (cnt_q != 2'd2);
	assign rd_vld = (cnt_q != 2'd0);
	assign rd_data = mem_q[rp_q];
	assign wr = wr_vld && wr_rdy;
	assign rd = rd_vld && rd_rdy;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end
endmodule
`default_nettype wire

// File: hdl/tzrp_back.sv
// ----------------------------------------------------------------------------
// tzrp_back
// expands queued work into one or two results with a registered output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tzrp_back (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       wk_vld,
	input  wire tzrp_pkg::work_t wk,
	output logic            wk_rdy,
	output logic            out_vld,
	output tzrp_pkg::result_t out_res,
	input  wire logic       out_rdy
);
	logic            name_done_q;
	logic            load, two;
	tzrp_pkg::result_t nxt;

	assign two = wk.name_vld && wk.verd_vld;
	assign load = wk_vld && (!out_vld || out_rdy);
	assign wk_rdy = load && (!two || name_done_q);

	always_comb begin
		nxt = '0;
		if (wk.name_vld && !name_done_q) begin
			nxt.result_kind = wk.name_side ? 2'(tzrp_pkg::KIND_DAY) : 2'(tzrp_pkg::KIND_STD);
			nxt.name_char = wk.name_char;
			nxt.name_final = wk.name_final;
			nxt.run_last = !wk.verd_vld;
		end else begin
			nxt.result_kind = 2'(tzrp_pkg::KIND_VERDICT);
			nxt.status = wk.verd_bad;
			if (!wk.verd_bad) begin
				nxt.standard_present = wk.presence[0];
				nxt.daylight_present = wk.presence[1];
				nxt.tick_offset = wk.offset;
			end
			nxt.run_last = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) out_res <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
			name_done_q <= 1'b0;
		end else begin
			if (load) out_vld <= 1'b1;
			else if (out_rdy) out_vld <= 1'b0;
			if (load) name_done_q <= two && !name_done_q;
		end
	end
endmodule
`default_nettype wire

// File: hdl/timezone_record_parser_top.sv
// ----------------------------------------------------------------------------
// timezone_record_parser_top
// streaming checker and name extractor for serialized time-zone records
// ----------------------------------------------------------------------------
// One record byte is taken per clock cycle while the work queue has room.
// A byte yields at most two results (a name byte and a verdict), which the
// single result register of the back end sends in turn. Every other byte
// flows at one per cycle through the two-entry work queue if nothing stalls.
`timescale 1ns / 1ps
`default_nettype none
`include "timezone_record_parser_top_assert.svh"
module timezone_record_parser_top #(
	parameter int NAME_LIMIT = tzrp_pkg::NameLimitDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	tzrp_stream_if.sink   in_ch,
	tzrp_stream_if.source out_ch
);
	logic            f_vld, f_rdy, q_vld, q_rdy;
	tzrp_pkg::work_t f_wk, q_wk;
	tzrp_pkg::item_t item;
	tzrp_pkg::result_t res;

	assign item = in_ch.payload;
	assign out_ch.payload = res;

	tzrp_front #(.NAME_LIMIT(NAME_LIMIT)) u_front (
		.clk, .arst_n, .in_vld(in_ch.valid), .in_item(item), .in_rdy(in_ch.ready),
		.wk_vld(f_vld), .wk(f_wk), .wk_rdy(f_rdy)
	);
	tzrp_queue u_queue (
		.clk, .arst_n, .wr_vld(f_vld), .wr_data(f_wk), .wr_rdy(f_rdy),
		.rd_vld(q_vld), .rd_data(q_wk), .rd_rdy(q_rdy)
	);
	tzrp_back u_back (
		.clk, .arst_n, .wk_vld(q_vld), .wk(q_wk), .wk_rdy(q_rdy),
		.out_vld(out_ch.valid), .out_res(res), .out_rdy(out_ch.ready)
	);

	`TZRP_NEVER(a_verdict_no_name, clk, arst_n, out_ch.valid && res.result_kind == 2'(tzrp_pkg::KIND_VERDICT) && res.name_char != 8'd0, "verdict carries a name byte")
	`TZRP_NEVER(a_bad_clean, clk, arst_n, out_ch.valid && res.status && (res.tick_offset != 64'd0 || res.standard_present), "malformed verdict with data")
	`TZRP_ASSERT(a_eos_queued, clk, arst_n, (f_vld && f_rdy && item.end_of_stream) |=> q_vld, "end of stream work not queued")
endmodule
`default_nettype wire

// File: tb/timezone_record_parser_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timezone_record_parser_top_tb
// self-checking bench for the time-zone record parser
// ----------------------------------------------------------------------------
// Well-formed records with random ids, offsets and names are streamed in,
// mixed with corrupted, truncated and noise records. A byte-level parser
// model predicts name bytes and verdicts, and the monitor compares each
// output transaction field by field. Both sides idle in random bursts.
module timezone_record_parser_top_tb;
	import tzrp_pkg::*;

	localparam int NameLimit = NameLimitDefault;
	localparam int CycleLimit = 400000;

	logic clk;
	logic arst_n;

	tzrp_stream_if #(.payload_t(item_t)) in_ch ();
	tzrp_stream_if #(.payload_t(result_t)) out_ch ();

	timezone_record_parser_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	item_t pending_bytes[$];
	result_t expected_results[$];
	int errors = 0;
	int bytes_sent = 0;
	int results_seen = 0;
	int verdicts_seen = 0;
	int cycle_count = 0;
	bit hold_sender = 0;
	bit quiet = 0;
	int src_idle = 0;
	int snk_idle = 0;

	string tmpl_text[6] = '{"System.CurrentSystemTimeZone",
		{string'("m_Cached"), "DaylightChanges"}, {string'("m_ticks"), "Offset"},
		{string'("m_standard"), "Name"}, {string'("m_daylight"), "Name"},
		"System.Collections.Hashtable"};
	phase_t tmpl_len_ph[6] = '{PH_TZ_LEN, PH_M0_LEN, PH_M1_LEN, PH_M2_LEN, PH_M3_LEN, PH_HT_LEN};
	phase_t tmpl_next_ph[6] = '{PH_COUNT, PH_M1_LEN, PH_M2_LEN, PH_M3_LEN, PH_TYPES, PH_PRIM};
	logic [7:0] type_code[4] = '{8'd3, 8'd0, 8'd1, 8'd1};

	// parser model state
	phase_t     m_phase;
	int         m_pos;
	logic [63:0] m_len;
	int         m_vcnt;
	logic [31:0] m_word;
	logic [63:0] m_offset;
	int         m_left;
	logic [1:0] m_present;
	bit         m_done;

	function automatic void goto_phase(phase_t nxt);
		m_phase = nxt;
		m_pos = 0;
		m_word = '0;
		m_len = '0;
		m_vcnt = 0;
	endfunction

	function automatic void parser_reset();
		goto_phase(PH_HDR_TAG);
		m_offset = '0;
		m_left = 0;
		m_present = '0;
		m_done = 0;
	endfunction

	// 1 complete, 0 more to come, -1 too long
	function automatic int take_varint(logic [7:0] b);
		m_len = m_len | (64'(b[6:0]) << (7 * (m_vcnt & 7)));
		m_vcnt++;
		if (b[7]) return (m_vcnt >= 5) ? -1 : 0;
		return 1;
	endfunction

	function automatic result_t verdict_of(bit ok);
		result_t r;
		r = '0;
		r.result_kind = KIND_VERDICT;
		if (ok) begin
			r.standard_present = m_present[0];
			r.daylight_present = m_present[1];
			r.tick_offset = m_offset;
		end else begin
			r.status = 1'b1;
		end
		m_done = 1;
		goto_phase(PH_DONE);
		return r;
	endfunction

	function automatic void predict_byte(item_t it);
		result_t outs[$];
		result_t r;
		logic [7:0] b;
		bit bad;
		bit side;
		int v;
		b = it.data_byte;
		bad = 0;
		side = (m_phase >= PH_DAY_TAG && m_phase <= PH_DAY_BODY);
		case (m_phase)
			PH_HDR_TAG: begin
				if (b != 8'd0) bad = 1; else goto_phase(PH_HDR_IDS);
			end
			PH_HDR_IDS: begin
				if (++m_pos >= 8) goto_phase(PH_MAJOR);
			end
			PH_MAJOR, PH_COUNT: begin
				m_word = m_word | (32'(b) << (8 * (m_pos & 3)));
				if (++m_pos >= 4) begin
					if (m_phase == PH_MAJOR) begin
						if (m_word != 32'd1) bad = 1; else goto_phase(PH_MINOR);
					end else begin
						if (m_word != 32'd4) bad = 1; else goto_phase(PH_M0_LEN);
					end
				end
			end
			PH_MINOR: begin
				if (++m_pos >= 4) goto_phase(PH_CLS_TAG);
			end
			PH_CLS_TAG: begin
				if (b != 8'd4) bad = 1; else goto_phase(PH_CLS_ID);
			end
			PH_CLS_ID: begin
				if (++m_pos >= 4) goto_phase(PH_TZ_LEN);
			end
			PH_TYPES: begin
				if (b != type_code[m_pos & 3]) bad = 1;
				else if (++m_pos >= 4) goto_phase(PH_HT_LEN);
			end
			PH_PRIM: begin
				if (b != 8'd9) bad = 1; else goto_phase(PH_CACHE_TAG);
			end
			PH_CACHE_TAG: begin
				if (b == 8'd9) goto_phase(PH_CACHE_REF);
				else if (b == 8'd10) goto_phase(PH_OFFSET);
				else bad = 1;
			end
			PH_CACHE_REF: begin
				if (++m_pos >= 4) goto_phase(PH_OFFSET);
			end
			PH_OFFSET: begin
				m_offset = m_offset | (64'(b) << (8 * (m_pos & 7)));
				if (++m_pos >= 8) goto_phase(PH_STD_TAG);
			end
			PH_STD_TAG, PH_DAY_TAG: begin
				if (b == 8'd6) goto_phase(side ? PH_DAY_ID : PH_STD_ID);
				else if (b != 8'd10) bad = 1;
				else if (side) outs.push_back(verdict_of(1));
				else goto_phase(PH_DAY_TAG);
			end
			PH_STD_ID, PH_DAY_ID: begin
				if (++m_pos >= 4) goto_phase(side ? PH_DAY_LEN : PH_STD_LEN);
			end
			PH_STD_LEN, PH_DAY_LEN: begin
				v = take_varint(b);
				if (v < 0 || (v > 0 && m_len >= 64'(NameLimit))) begin
					bad = 1;
				end else if (v > 0) begin
					m_left = int'(m_len);
					if (m_left == 0) begin
						m_present[side] = 1'b1;
						if (side) outs.push_back(verdict_of(1)); else goto_phase(PH_DAY_TAG);
					end else begin
						goto_phase(side ? PH_DAY_BODY : PH_STD_BODY);
					end
				end
			end
			PH_STD_BODY, PH_DAY_BODY: begin
				if (m_left > 0) m_left--;
				r = '0;
				r.result_kind = side ? KIND_DAY : KIND_STD;
				r.name_char = b;
				r.name_final = (m_left == 0);
				outs.push_back(r);
				if (m_left == 0) begin
					m_present[side] = 1'b1;
					if (side) outs.push_back(verdict_of(1)); else goto_phase(PH_DAY_TAG);
				end
			end
			PH_DONE: ;
			default: begin
				bad = 1;
				for (int i = 0; i < 6; i++) begin
					if (m_phase == tmpl_len_ph[i]) begin
						bad = 0;
						v = take_varint(b);
						if (v < 0 || (v > 0 && m_len != 64'(tmpl_text[i].len()))) bad = 1;
						else if (v > 0) goto_phase(phase_t'(tmpl_len_ph[i] + 1));
						break;
					end
					if (m_phase == tmpl_len_ph[i] + 1) begin
						bad = 0;
						if (m_pos >= tmpl_text[i].len() || b != 8'(tmpl_text[i][m_pos])) bad = 1;
						else if (++m_pos >= tmpl_text[i].len()) goto_phase(tmpl_next_ph[i]);
						break;
					end
				end
			end
		endcase
		if (bad) outs.push_back(verdict_of(0));
		if (it.end_of_stream) begin
			if (!m_done) outs.push_back(verdict_of(0));
			parser_reset();
		end
		if (outs.size() > 0) outs[outs.size() - 1].run_last = 1'b1;
		foreach (outs[i]) expected_results.push_back(outs[i]);
	endfunction

	// record construction
	logic [7:0] rec[$];

	task automatic put_varint(int value, int extra);
		int n;
		n = 1;
		while ((value >> (7 * n)) != 0 && n < 5) n++;
		n = n + extra;
		if (n > 5) n = 5;
		for (int i = 0; i < n; i++)
			rec.push_back({(i != n - 1), 7'((value >> (7 * i)) & 8'h7F)});
	endtask

	task automatic put_rand(int n);
		repeat (n) rec.push_back(8'($urandom));
	endtask

	task automatic put_text(int idx);
		put_varint(tmpl_text[idx].len(), ($urandom_range(0, 5) == 0) ? 1 : 0);
		for (int i = 0; i < tmpl_text[idx].len(); i++) rec.push_back(8'(tmpl_text[idx][i]));
	endtask

	// name_mode: 0 null, 1 string, 2 empty, 3 overlong, 4 runaway varint
	task automatic put_name(int name_mode, int len);
		if (name_mode == 0) begin
			rec.push_back(8'd10);
			return;
		end
		rec.push_back(8'd6);
		put_rand(4);
		case (name_mode)
			1: begin
				put_varint(len, $urandom_range(0, 1));
				put_rand(len);
			end
			2: put_varint(0, $urandom_range(0, 3));
			3: put_varint($urandom_range(NameLimit, NameLimit + 200), 0);
			default: repeat (5) rec.push_back(8'h80 | 8'($urandom));
		endcase
	endtask

	task automatic build_record(int std_mode, int std_len, int day_mode, int day_len,
			logic [63:0] offset);
		rec.delete();
		rec.push_back(8'd0);
		put_rand(8);
		rec.push_back(8'd1); rec.push_back(8'd0); rec.push_back(8'd0); rec.push_back(8'd0);
		put_rand(4);
		rec.push_back(8'd4);
		put_rand(4);
		put_text(0);
		rec.push_back(8'd4); rec.push_back(8'd0); rec.push_back(8'd0); rec.push_back(8'd0);
		for (int i = 1; i <= 4; i++) put_text(i);
		foreach (type_code[i]) rec.push_back(type_code[i]);
		put_text(5);
		rec.push_back(8'd9);
		if ($urandom_range(0, 1)) begin
			rec.push_back(8'd9);
			put_rand(4);
		end else begin
			rec.push_back(8'd10);
		end
		for (int i = 0; i < 8; i++) rec.push_back(offset[8 * i +: 8]);
		put_name(std_mode, std_len);
		put_name(day_mode, day_len);
	endtask

	task automatic queue_record(int trailing);
		item_t it;
		put_rand(trailing);
		foreach (rec[i]) begin
			it.data_byte = rec[i];
			it.end_of_stream = (i == rec.size() - 1);
			pending_bytes.push_back(it);
		end
	endtask

	function automatic int pick_len();
		case ($urandom_range(0, 3))
			0: return 1;
			1: return NameLimit - 1;
			default: return $urandom_range(1, 12);
		endcase
	endfunction

	task automatic random_record();
		int sel;
		int idx;
		logic [63:0] off;
		off = {$urandom, $urandom};
		build_record($urandom_range(0, 2), pick_len(), $urandom_range(0, 2), pick_len(), off);
		sel = $urandom_range(0, 9);
		if (sel == 7) begin
			idx = $urandom_range(0, rec.size() - 1);
			rec[idx] = rec[idx] ^ 8'($urandom_range(1, 255));
		end else if (sel == 8) begin
			idx = $urandom_range(1, rec.size() - 1);
			while (rec.size() > idx) void'(rec.pop_back());
		end else if (sel == 9) begin
			rec.delete();
			put_rand($urandom_range(1, 10));
		end
		queue_record($urandom_range(0, 3));
	endtask

	task automatic directed_records();
		rec.delete(); rec.push_back(8'd0); queue_record(0);
		rec.delete(); rec.push_back(8'd5); queue_record(2);
		build_record(2, 0, 2, 0, 64'h8000_0000_0000_0000); queue_record(0);
		build_record(1, NameLimit - 1, 3, 0, 64'hFFFF_FFFF_FFFF_FFFF); queue_record(2);
		build_record(4, 0, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF); queue_record(1);
		build_record(1, 5, 1, 4, 64'h0123_4567_89AB_CDEF);
		void'(rec.pop_back());
		queue_record(0);
	endtask

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.payload <= '0;
			src_idle <= 0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (in_ch.valid) bytes_sent <= bytes_sent + 1;
			if (src_idle > 0) begin
				src_idle <= src_idle - 1;
				in_ch.valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				src_idle <= $urandom_range(0, 3);
				in_ch.valid <= 1'b0;
			end else if (!hold_sender && pending_bytes.size() > 0) begin
				in_ch.payload <= pending_bytes[0];
				predict_byte(pending_bytes[0]);
				void'(pending_bytes.pop_front());
				in_ch.valid <= 1'b1;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			snk_idle <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					$error("unexpected output transaction kind %0d", out_ch.payload.result_kind);
					errors <= errors + 1;
				end else begin
					result_t e;
					result_t a;
					int bad_fields;
					bad_fields = 0;
					e = expected_results.pop_front();
					a = out_ch.payload;
					if (e.result_kind == KIND_VERDICT) verdicts_seen <= verdicts_seen + 1;
					if (a.result_kind !== e.result_kind) begin
						$error("result_kind expected %0d got %0d", e.result_kind, a.result_kind);
						bad_fields++;
					end
					if (a.name_char !== e.name_char) begin
						$error("name_char expected %h got %h", e.name_char, a.name_char);
						bad_fields++;
					end
					if (a.name_final !== e.name_final) begin
						$error("name_final expected %0d got %0d", e.name_final, a.name_final);
						bad_fields++;
					end
					if (a.status !== e.status) begin
						$error("status expected %0d got %0d", e.status, a.status);
						bad_fields++;
					end
					if (a.standard_present !== e.standard_present) begin
						$error("standard_present expected %0d got %0d",
							e.standard_present, a.standard_present);
						bad_fields++;
					end
					if (a.daylight_present !== e.daylight_present) begin
						$error("daylight_present expected %0d got %0d",
							e.daylight_present, a.daylight_present);
						bad_fields++;
					end
					if (a.tick_offset !== e.tick_offset) begin
						$error("tick_offset expected %h got %h", e.tick_offset, a.tick_offset);
						bad_fields++;
					end
					if (a.run_last !== e.run_last) begin
						$error("run_last expected %0d got %0d", e.run_last, a.run_last);
						bad_fields++;
					end
					if (bad_fields > 0) errors <= errors + bad_fields;
				end
			end
			if (snk_idle > 0) begin
				snk_idle <= snk_idle - 1;
				out_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				snk_idle <= $urandom_range(0, 3);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		parser_reset();
		directed_records();
		while (pending_bytes.size() < 450) random_record();
		@(posedge arst_n);
		while (pending_bytes.size() > 0) @(posedge clk);
		hold_sender = 1;
		while (in_ch.valid || expected_results.size() > 0) @(posedge clk);
		hold_sender = 0;
		while (pending_bytes.size() < 100) random_record();
		while (pending_bytes.size() > 60) @(posedge clk);
		quiet = 1;
		while (pending_bytes.size() > 0 || in_ch.valid) @(posedge clk);
		while (expected_results.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (expected_results.size() > 0) begin
			$error("%0d expected transactions never arrived", expected_results.size());
			errors = errors + 1;
		end
		$display("sent %0d record bytes, checked %0d output transactions (%0d verdicts)",
			bytes_sent, results_seen, verdicts_seen);
		$display("records: clean, corrupted, truncated, noise, null/empty/overlong names");
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
